[hdl/rcr_pkg.sv]
// ============================================================================
// rcr_pkg - shared types and constants for the column raycaster
// Holds the controller state type, the command/status structs and tables.
// ============================================================================
package rcr_pkg;

    localparam int MAP_SIZE   = 16;
    localparam int MAX_ROWS   = 64;
    localparam int ANGLE_BITS = 12;

    // configuration register indexes
    localparam logic [2:0] REG_MAP_A  = 3'd0;
    localparam logic [2:0] REG_MAP_B  = 3'd1;
    localparam logic [2:0] REG_MAP_C  = 3'd2;
    localparam logic [2:0] REG_MAP_D  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_SPAN   = 3'd6;
    localparam logic [2:0] REG_DEPTH  = 3'd7;

    localparam logic [15:0] GLYPH_BLANK  = 16'h0020;
    localparam logic [15:0] GLYPH_FULL   = 16'h2588;
    localparam logic [15:0] GLYPH_DARK   = 16'h2593;
    localparam logic [15:0] GLYPH_MEDIUM = 16'h2592;
    localparam logic [15:0] GLYPH_LIGHT  = 16'h2591;
    localparam logic [15:0] GLYPH_HASH   = 16'h0023;
    localparam logic [15:0] GLYPH_X      = 16'h0078;
    localparam logic [15:0] GLYPH_DOT    = 16'h002E;
    localparam logic [15:0] GLYPH_UNDER  = 16'h005F;

    localparam logic [17:0] CELL_SCALE = 18'd163840;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ANGLE,
        ST_SIN,
        ST_MUL,
        ST_MARCH,
        ST_CDIV,
        ST_SHADE,
        ST_ROWS
    } state_t;

    typedef struct packed {
        logic load;        // capture input word, start offset division
        logic div_step;    // one quotient bit of the offset divide
        logic angle;       // form the ray angle
        logic sin_lookup;  // table lookup for both trig values
        logic sin_finish;  // finish both trig values
        logic march_step;  // advance the ray one step
        logic cdiv_start;  // start the ceiling division
        logic cdiv_step;   // one quotient bit of the ceiling divide
        logic shade;       // form ceiling/floor rows and wall shade
        logic row_emit;    // emit one row
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic march_done;
        logic cdiv_done;
        logic last_row;
    } status_t;

    function automatic logic [14:0] quarter_sine(input logic [4:0] i);
        logic [14:0] v;
        begin
            case (i)
                5'd0:  v = 15'd0;
                5'd1:  v = 15'd1606;
                5'd2:  v = 15'd3196;
                5'd3:  v = 15'd4756;
                5'd4:  v = 15'd6270;
                5'd5:  v = 15'd7723;
                5'd6:  v = 15'd9102;
                5'd7:  v = 15'd10394;
                5'd8:  v = 15'd11585;
                5'd9:  v = 15'd12665;
                5'd10: v = 15'd13623;
                5'd11: v = 15'd14449;
                5'd12: v = 15'd15137;
                5'd13: v = 15'd15679;
                5'd14: v = 15'd16069;
                5'd15: v = 15'd16305;
                default: v = 15'd16384;
            endcase
            return v;
        end
    endfunction

endpackage

[hdl/rcr_ctrl.sv]
// ============================================================================
// rcr_ctrl - controller for the column raycaster
// Sequences divide, trig, march, ceiling divide and row emission.
// ============================================================================
module rcr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rcr_pkg::status_t   status,
    output logic               busy,
    output rcr_pkg::cmd_t      cmd
);

    rcr_pkg::state_t state_reg;
    rcr_pkg::state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rcr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcr_pkg::ST_IDLE:  if (start) state_next = rcr_pkg::ST_DIV;
            rcr_pkg::ST_DIV:   if (status.div_done) state_next = rcr_pkg::ST_ANGLE;
            rcr_pkg::ST_ANGLE: state_next = rcr_pkg::ST_SIN;
            rcr_pkg::ST_SIN:   state_next = rcr_pkg::ST_MUL;
            rcr_pkg::ST_MUL:   state_next = rcr_pkg::ST_MARCH;
            rcr_pkg::ST_MARCH: if (status.march_done) state_next = rcr_pkg::ST_CDIV;
            rcr_pkg::ST_CDIV:  if (status.cdiv_done) state_next = rcr_pkg::ST_SHADE;
            rcr_pkg::ST_SHADE: state_next = rcr_pkg::ST_ROWS;
            rcr_pkg::ST_ROWS:  if (status.last_row) state_next = rcr_pkg::ST_IDLE;
            default:           state_next = rcr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            rcr_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            rcr_pkg::ST_DIV:   cmd.div_step   = 1'b1;
            rcr_pkg::ST_ANGLE: cmd.angle      = 1'b1;
            rcr_pkg::ST_SIN:   cmd.sin_lookup = 1'b1;
            rcr_pkg::ST_MUL:   cmd.sin_finish = 1'b1;
            rcr_pkg::ST_MARCH:
            begin
                cmd.march_step = 1'b1;
                cmd.cdiv_start = status.march_done;
            end
            rcr_pkg::ST_CDIV:  cmd.cdiv_step  = 1'b1;
            rcr_pkg::ST_SHADE: cmd.shade      = 1'b1;
            rcr_pkg::ST_ROWS:  cmd.row_emit   = 1'b1;
            default:           busy = 1'b1;
        endcase
    end

endmodule

[hdl/rcr_dp.sv]
// ============================================================================
// rcr_dp - datapath for the column raycaster
// Config registers, serial dividers, trig interpolation, ray marcher, rows.
// ============================================================================
module rcr_dp
#(
    parameter int MAX_ROWS   = rcr_pkg::MAX_ROWS,
    parameter int ANGLE_BITS = rcr_pkg::ANGLE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcr_pkg::cmd_t         cmd,
    output rcr_pkg::status_t      status,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic [7:0]            column,
    input  logic [11:0]           player_x,
    input  logic [11:0]           player_y,
    input  logic [ANGLE_BITS-1:0] player_angle,
    output logic                  strobe,
    output logic [5:0]            row,
    output logic [15:0]           glyph,
    output logic [7:0]            ray_steps,
    output logic                  last_row
);

    localparam int AB = ANGLE_BITS;
    localparam int HW = $clog2(MAX_ROWS + 1);

    // ---------------- configuration ----------------
    logic [63:0] map_a_reg, map_b_reg, map_c_reg, map_d_reg;
    logic [7:0]  width_reg;
    logic [6:0]  height_reg;
    logic [11:0] span_reg;
    logic [4:0]  depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_a_reg  <= 64'd9223794255762423807;
            map_b_reg  <= 64'd9223794255896610817;
            map_c_reg  <= 64'd9223794255762391041;
            map_d_reg  <= 64'd18446603342663778049;
            width_reg  <= 8'd120;
            height_reg <= 7'd40;
            span_reg   <= 12'd512;
            depth_reg  <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcr_pkg::REG_MAP_A:  map_a_reg  <= cfg_data;
                rcr_pkg::REG_MAP_B:  map_b_reg  <= cfg_data;
                rcr_pkg::REG_MAP_C:  map_c_reg  <= cfg_data;
                rcr_pkg::REG_MAP_D:  map_d_reg  <= cfg_data;
                rcr_pkg::REG_WIDTH:  width_reg  <= cfg_data[7:0];
                rcr_pkg::REG_HEIGHT: height_reg <= cfg_data[6:0];
                rcr_pkg::REG_SPAN:   span_reg   <= cfg_data[11:0];
                rcr_pkg::REG_DEPTH:  depth_reg  <= cfg_data[4:0];
                default:             map_a_reg  <= map_a_reg;
            endcase
        end
    end

    // saturated depth and height
    logic [4:0]    depth;
    logic [HW-1:0] h;
    always_comb
    begin
        depth = (depth_reg == 5'd0) ? 5'd1 : ((depth_reg > 5'd16) ? 5'd16 : depth_reg);
        if (height_reg < 7'd2)
            h = HW'(2);
        else if ({1'b0, height_reg} > 8'(MAX_ROWS))
            h = HW'(MAX_ROWS);
        else
            h = HW'(height_reg);
    end

    logic [7:0] limit;
    assign limit = 8'({depth, 3'b000}) + 8'({depth, 1'b0});

    // ---------------- input capture ----------------
    logic [11:0]   px_reg, py_reg;
    logic [AB-1:0] pangle_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg     <= player_x;
            py_reg     <= player_y;
            pangle_reg <= player_angle;
        end
    end

    // ---------------- offset divide: column*span / width ----------------
    logic [19:0] dnum_reg;   // dividend shifting out, quotient shifting in
    logic [8:0]  drem_reg;
    logic [4:0]  dcnt_reg;
    logic [8:0]  drem_sh;
    logic        dge;

    assign drem_sh = {drem_reg[7:0], dnum_reg[19]};
    assign dge     = drem_sh >= {1'b0, width_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dnum_reg <= 20'(column) * 20'(span_reg);
            drem_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dnum_reg <= {dnum_reg[18:0], dge};
            drem_reg <= dge ? (drem_sh - {1'b0, width_reg}) : drem_sh;
            dcnt_reg <= dcnt_reg + 5'd1;
        end
    end
    assign status.div_done = (dcnt_reg == 5'd19);

    // ---------------- ray angle ----------------
    logic [AB-1:0] ray_reg;
    logic [AB-1:0] offset;
    assign offset = (width_reg == 8'd0) ? '0 : AB'(dnum_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.angle)
            ray_reg <= pangle_reg - AB'(span_reg >> 1) + offset;
    end

    // ---------------- sine / cosine ----------------
    logic [AB-1:0] cray;
    assign cray = ray_reg + AB'(1 << (AB - 2));

    typedef struct packed {
        logic        neg;
        logic        full;
        logic [14:0] base;
        logic [14:0] delta;
        logic [9:0]  frac;
    } sin_part_t;

    function automatic sin_part_t sin_split(input logic [AB-1:0] a);
        logic [15:0] p;
        logic [14:0] u;
        logic [4:0]  i;
        sin_part_t   s;
        begin
            p = 16'({a, 16'b0} >> AB);
            u = p[14] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
            i = u[14:10];
            s.neg   = p[15];
            s.full  = (i >= 5'd16);
            s.base  = rcr_pkg::quarter_sine(i);
            s.delta = rcr_pkg::quarter_sine(i + 5'd1) - rcr_pkg::quarter_sine(i);
            s.frac  = u[9:0];
            return s;
        end
    endfunction

    sin_part_t sx_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sin_lookup)
        begin
            sx_reg <= sin_split(ray_reg);
            sy_reg <= sin_split(cray);
        end
    end

    logic [24:0] mx, my;
    assign mx = 25'(sx_reg.delta) * 25'(sx_reg.frac);
    assign my = 25'(sy_reg.delta) * 25'(sy_reg.frac);

    logic signed [15:0] dx_reg, dy_reg;
    logic [14:0] magx, magy;
    assign magx = sx_reg.full ? 15'd16384 : (sx_reg.base + 15'(mx >> 10));
    assign magy = sy_reg.full ? 15'd16384 : (sy_reg.base + 15'(my >> 10));

    always_ff @(posedge clk)
    begin
        if (cmd.sin_finish)
        begin
            dx_reg <= sx_reg.neg ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
            dy_reg <= sy_reg.neg ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
        end
    end

    // ---------------- ray march ----------------
    // position in units of 1/163840 cell, accumulated by step each cycle until the march is done
    logic signed [23:0] posx_reg, posy_reg;
    logic [7:0]         n_reg;
    logic               mdone_reg;
    logic signed [23:0] nposx, nposy;
    logic [4:0]         cx, cy;
    logic               outside, wall;

    assign nposx = posx_reg + 24'(dx_reg);
    assign nposy = posy_reg + 24'(dy_reg);

    // cell index of the probed point: value / 163840, value < 2^22
    // estimate with a reciprocal that rounds low, then correct up by one
    always_comb
    begin
        cx = 5'((36'(nposx[21:0]) * 36'd6553) >> 30);
        cy = 5'((36'(nposy[21:0]) * 36'd6553) >> 30);
        if ({2'b00, nposx[21:0]} >= 24'(cx + 5'd1) * 24'(rcr_pkg::CELL_SCALE))
            cx = cx + 5'd1;
        if ({2'b00, nposy[21:0]} >= 24'(cy + 5'd1) * 24'(rcr_pkg::CELL_SCALE))
            cy = cy + 5'd1;
    end

    logic [63:0] map_sel;
    always_comb
    begin
        case (cy[3:2])
            2'd0:    map_sel = map_a_reg;
            2'd1:    map_sel = map_b_reg;
            2'd2:    map_sel = map_c_reg;
            default: map_sel = map_d_reg;
        endcase
    end

    assign outside = nposx[23] || nposy[23] || cx[4] || cy[4];
    assign wall    = map_sel[{cy[1:0], cx[3:0]}];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mdone_reg <= 1'b0;
            n_reg     <= '0;
        end
        else if (cmd.sin_finish)
        begin
            mdone_reg <= 1'b0;
            n_reg     <= '0;
        end
        else if (cmd.march_step && !mdone_reg)
        begin
            if (n_reg >= limit)
                mdone_reg <= 1'b1;
            else
            begin
                n_reg <= outside ? limit : n_reg + 8'd1;
                mdone_reg <= outside || wall;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sin_finish)
        begin
            posx_reg <= 24'(px_reg) * 24'd640;
            posy_reg <= 24'(py_reg) * 24'd640;
        end
        else if (cmd.march_step && !mdone_reg)
        begin
            posx_reg <= nposx;
            posy_reg <= nposy;
        end
    end
    assign status.march_done = mdone_reg;

    // ---------------- ceiling divide: (h*n - 20h) / 2n, toward zero -----
    logic [14:0] cnum_reg;   // magnitude of numerator, quotient in
    logic [8:0]  crem_reg;
    logic [3:0]  ccnt_reg;
    logic        cneg_reg;
    logic [9:0]  crem_sh;
    logic        cge;
    logic [14:0] hn, h20;

    assign hn      = 15'(h) * 15'(n_reg);
    assign h20     = 15'(h) * 15'd20;
    assign crem_sh = {crem_reg, cnum_reg[14]};
    assign cge     = crem_sh >= {1'b0, n_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.cdiv_start)
        begin
            cneg_reg <= hn < h20;
            cnum_reg <= (hn < h20) ? (h20 - hn) : (hn - h20);
            crem_reg <= '0;
            ccnt_reg <= '0;
        end
        else if (cmd.cdiv_step)
        begin
            cnum_reg <= {cnum_reg[13:0], cge};
            crem_reg <= cge ? 9'(crem_sh - {1'b0, n_reg, 1'b0}) : crem_sh[8:0];
            ccnt_reg <= ccnt_reg + 4'd1;
        end
    end
    assign status.cdiv_done = (ccnt_reg == 4'd14);

    // ---------------- shade and rows ----------------
    logic signed [15:0] ceil_reg, floor_reg;
    logic [15:0]        shade_reg;
    logic [HW-1:0]      y_reg;
    logic [9:0]         n2, d5, n3, d10;

    assign n2  = {1'b0, n_reg, 1'b0};
    assign n3  = 10'(n_reg) * 10'd3;
    assign d5  = 10'(depth) * 10'd5;
    assign d10 = 10'(depth) * 10'd10;

    logic [HW-1:0] k;
    logic signed [15:0] ys;
    logic [15:0] fl_glyph;
    logic        fl_set;
    assign k  = h - y_reg;
    assign ys = 16'(y_reg);

    always_comb
    begin
        fl_set   = 1'b1;
        fl_glyph = shade_reg;
        if (12'(k) * 12'd8 < 12'(h))
            fl_glyph = rcr_pkg::GLYPH_HASH;
        else if (12'(k) * 12'd4 < 12'(h))
            fl_glyph = rcr_pkg::GLYPH_X;
        else if (12'(k) * 12'd8 < 12'(h) * 12'd3)
            fl_glyph = rcr_pkg::GLYPH_DOT;
        else if (12'(k) * 12'd20 < 12'(h) * 12'd9)
            fl_glyph = rcr_pkg::GLYPH_UNDER;
        else
            fl_set = 1'b0;
    end

    logic [15:0] g;
    always_comb
    begin
        if (ys < ceil_reg)
            g = rcr_pkg::GLYPH_BLANK;
        else if (ys > ceil_reg && ys <= floor_reg)
            g = shade_reg;
        else
            g = fl_glyph;
    end

    logic signed [15:0] cq;
    assign cq = cneg_reg ? -$signed({1'b0, cnum_reg}) : $signed({1'b0, cnum_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.shade)
        begin
            ceil_reg  <= cq;
            floor_reg <= $signed(16'(h)) - cq;
            if (n2 <= d5)
                shade_reg <= rcr_pkg::GLYPH_FULL;
            else if (n3 <= d10)
                shade_reg <= rcr_pkg::GLYPH_DARK;
            else if (10'(n_reg) <= d5)
                shade_reg <= rcr_pkg::GLYPH_MEDIUM;
            else
                shade_reg <= rcr_pkg::GLYPH_LIGHT;
        end
        else if (cmd.row_emit && !(ys < ceil_reg) && !(ys > ceil_reg && ys <= floor_reg)
                 && fl_set)
            shade_reg <= fl_glyph;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            y_reg <= '0;
        else if (cmd.shade)
            y_reg <= '0;
        else if (cmd.row_emit)
            y_reg <= y_reg + HW'(1);
    end

    // registered result word
    logic        strobe_reg;
    logic [5:0]  row_reg;
    logic [15:0] glyph_reg;
    logic        last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.row_emit;
    end
    always_ff @(posedge clk)
    begin
        row_reg   <= 6'(y_reg);
        glyph_reg <= g;
        last_reg  <= (y_reg == h - HW'(1));
    end

    assign status.last_row = cmd.row_emit && (y_reg == h - HW'(1));
    assign strobe    = strobe_reg;
    assign row       = row_reg;
    assign glyph     = glyph_reg;
    assign ray_steps = n_reg;
    assign last_row  = last_reg;

endmodule

[hdl/raycast_column_renderer.sv]
// ============================================================================
// raycast_column_renderer - fixed step grid raycaster, one column per word
// Casts a ray through a 16x16 wall map and emits one glyph per screen row.
// ============================================================================
//  channel  | handshake         | payload
//  input    | start / busy      | column, player_x, player_y, player_angle
//  result   | strobe (no stall) | row, glyph, ray_steps, last_row
//  config   | cfg_we            | cfg_index, cfg_data
//
// One word runs the serial offset divide, the ray march of n steps (max 160),
// the serial ceiling divide and then one row per cycle for the H screen rows;
// busy stays high, and no new word is taken, until the last row is emitted.
// Reset restores the default map and view registers. Results are strobed
// for one cycle each; the receiver cannot stall them.
module raycast_column_renderer
#(
    parameter int MAX_ROWS   = rcr_pkg::MAX_ROWS,
    parameter int ANGLE_BITS = rcr_pkg::ANGLE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [7:0]            column,
    input  logic [11:0]           player_x,
    input  logic [11:0]           player_y,
    input  logic [ANGLE_BITS-1:0] player_angle,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    output logic                  strobe,
    output logic [5:0]            row,
    output logic [15:0]           glyph,
    output logic [7:0]            ray_steps,
    output logic                  last_row
);

    rcr_pkg::cmd_t    cmd;
    rcr_pkg::status_t status;

    rcr_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    rcr_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .column       (column),
        .player_x     (player_x),
        .player_y     (player_y),
        .player_angle (player_angle),
        .strobe       (strobe),
        .row          (row),
        .glyph        (glyph),
        .ray_steps    (ray_steps),
        .last_row     (last_row)
    );

endmodule
